[src/kmcs_pkg.sv]
// Shared types, constants and helpers for the key matrix change scanner.
// No dependencies; used by every module of the block.
package kmcs_pkg;

    localparam int COLUMNS   = 8;
    localparam int COL_W     = 3;
    localparam int ROW_W     = 8;
    localparam int BTN_W     = 6;
    localparam int IN_DATA_W = 72;
    localparam int OUT_DATA_W = 8;
    localparam int PADDR_W   = 3;

    localparam logic [COL_W-1:0] COL_LAST = COL_W'(COLUMNS - 1);

    // Register index of events_enabled
    localparam logic [0:0] REG_EVENTS_EN = 1'b0;

    localparam logic [ROW_W-1:0] MASK_ODD  = 8'hAA;
    localparam logic [ROW_W-1:0] MASK_PAIR = 8'hCC;
    localparam logic [ROW_W-1:0] MASK_HIGH = 8'hF0;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FLUSH
    } t_state;

    typedef struct packed {
        logic             pressed;
        logic [BTN_W-1:0] button_number;
        logic             last_event;
    } t_evt;

    typedef struct packed {
        logic busy;
        logic armed;
    } t_scan_stat;

    // Row position from the flag byte; exact for a single set bit, ORed otherwise
    function automatic logic [2:0] row_position(input logic [ROW_W-1:0] f);
        logic [2:0] p;
        p[0] = (f & MASK_ODD)  != '0;
        p[1] = (f & MASK_PAIR) != '0;
        p[2] = (f & MASK_HIGH) != '0;
        return p;
    endfunction

endpackage

[src/kmcs_ostage.sv]
// Output register of the event stream: one item slot in front of the master port.
// Depends on kmcs_pkg (t_evt).
module kmcs_ostage
    import kmcs_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_evt i_evt,
    output logic o_free,
    output logic o_valid,
    output t_evt o_evt,
    input  logic i_ready
);

    logic r_v;
    t_evt r_evt;

    assign o_free  = !r_v || i_ready;
    assign o_valid = r_v;
    assign o_evt   = r_evt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= 1'b0;
        end else if (i_push) begin
            r_v <= 1'b1;
        end else if (i_ready) begin
            r_v <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_evt <= i_evt;
        end
    end

endmodule

[src/kmcs_scan.sv]
// Column sequencer with the old-rows memory: read, compare, write back one column a cycle,
// unless the output stalls. Depends on kmcs_pkg (states, event struct, row_position).
module kmcs_scan
    import kmcs_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [IN_DATA_W-1:0] i_in_data,
    input  logic                 i_events_en,
    input  logic                 i_evt_free,
    output logic                 o_push,
    output t_evt                 o_evt,
    output t_scan_stat           o_stat
);

    t_state r_state, n_state;
    logic   r_armed;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_flags;
    logic [COLUMNS*ROW_W-1:0] r_rows;
    logic [2:0] r_pos;
    logic [COLUMNS-1:0] r_valid;
    logic r_pend_v;
    t_evt r_pend;

    logic [ROW_W-1:0] mem [COLUMNS];
    logic [ROW_W-1:0] r_rd;

    logic [ROW_W-1:0] in_flags;
    logic accept, start, changed, need_push, stall, mem_we;
    logic [ROW_W-1:0] act, old;

    assign in_flags = i_in_data[ROW_W-1:0];
    assign accept   = i_in_valid && o_in_ready;
    assign start    = accept && (in_flags != '0) && r_armed;

    // Entry never written since reset reads as zero
    assign act     = r_rows[ROW_W*r_col +: ROW_W];
    assign old     = r_valid[r_col] ? r_rd : '0;
    assign changed = ((act ^ old) & r_flags) != '0;

    // An event is held back one step so the final one can carry last_event
    always_comb begin
        need_push = 1'b0;
        unique case (r_state)
            ST_SCAN:  need_push = changed && i_events_en && r_pend_v;
            ST_FLUSH: need_push = r_pend_v;
            default:  need_push = 1'b0;
        endcase
    end
    assign stall = need_push && !i_evt_free;

    always_comb begin
        n_state = r_state;
        n_col   = r_col;
        unique case (r_state)
            ST_IDLE: begin
                n_col = '0;
                if (start) begin
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (!stall) begin
                    n_col = r_col + 1'b1;
                    if (r_col == COL_LAST) begin
                        n_state = ST_FLUSH;
                    end
                end
            end
            ST_FLUSH: begin
                if (!stall) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_in_ready = (r_state == ST_IDLE);
        o_push     = need_push && i_evt_free;
        mem_we     = (r_state == ST_SCAN) && changed && !stall;
        o_evt      = r_pend;
        o_evt.last_event = (r_state == ST_FLUSH);
        o_stat.busy  = (r_state != ST_IDLE);
        o_stat.armed = r_armed;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_armed  <= 1'b0;
            r_valid  <= '0;
            r_pend_v <= 1'b0;
            r_col    <= '0;
        end else begin
            r_state <= n_state;
            r_col   <= n_col;
            if (accept && (in_flags != '0) && !r_armed) begin
                r_armed <= 1'b1;
            end else if (r_state == ST_FLUSH && !stall) begin
                r_armed <= 1'b0;
            end
            if (mem_we) begin
                r_valid[r_col] <= 1'b1;
            end
            if (mem_we && i_events_en) begin
                r_pend_v <= 1'b1;
            end else if (r_state == ST_FLUSH && !stall) begin
                r_pend_v <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (start) begin
            r_flags <= in_flags;
            r_rows  <= i_in_data[IN_DATA_W-1:ROW_W];
            r_pos   <= row_position(in_flags);
        end
        if (mem_we && i_events_en) begin
            r_pend.pressed       <= (act & r_flags) != '0;
            r_pend.button_number <= {r_col, r_pos};
            r_pend.last_event    <= 1'b0;
        end
    end

    // Read address runs one column ahead of the compare, or sits on it in a stall;
    // writes hit only the compared column and none in a stall, so no entry is shared.
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[r_col] <= act;
        end
        r_rd <= mem[n_col];
    end

endmodule

[src/key_matrix_change_scanner.sv]
// Key matrix change scanner, top level: APB config register, scan sequencer, output stage.
// Depends on kmcs_pkg, kmcs_scan and kmcs_ostage.
//
// Usage:
//   s_axis: one item per poll tick. tdata[7:0] change flags, tdata[71:8] row
//   bytes, byte k read while column k is driven.
//   m_axis: one item per key event. tdata[5:0] button number (column*8 + row
//   position), upper bits zero; tuser = pressed; tlast marks the final event
//   of a tick.
//   APB: register 0 at byte address 0, bit 0 = events_enabled. pready is tied
//   high; reads return the register.
// Timing: a zero-flag tick or a first flagged tick (debounce arm) is taken without
//   a scan. A scanning tick walks the old-rows memory one column per cycle while
//   the output stage does not stall. s_axis_tready is low from the accept through
//   the scan and the flush state. An event waits for the next changed column or
//   the flush state, so the final one can carry tlast, and shows on m_axis in the
//   cycle after it is handed to the output stage.
// Reset clears the armed flag, the events enable and the entry valid bits, so
//   all stored rows read as zero. A stalled m_axis holds the scan at the
//   column that needs to hand off an event; no event is dropped.
module key_matrix_change_scanner
    import kmcs_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,   // [7:0] change_flags, [71:8] scan_rows
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,   // [5:0] button_number, [7:6] zero
    output logic                  m_axis_tuser,   // [0] pressed
    output logic                  m_axis_tlast,   // last_event
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [PADDR_W-1:0]    paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    logic       r_events_en;
    logic       evt_free, push;
    t_evt       push_evt, out_evt;
    t_scan_stat stat;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_events_en <= 1'b0;
        end else if (psel && penable && pwrite && pready && paddr[2] == REG_EVENTS_EN) begin
            r_events_en <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == REG_EVENTS_EN) ? {31'b0, r_events_en} : 32'b0;

    kmcs_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_events_en (r_events_en),
        .i_evt_free  (evt_free),
        .o_push      (push),
        .o_evt       (push_evt),
        .o_stat      (stat)
    );

    kmcs_ostage u_ostage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_evt   (push_evt),
        .o_free  (evt_free),
        .o_valid (m_axis_tvalid),
        .o_evt   (out_evt),
        .i_ready (m_axis_tready)
    );

    assign m_axis_tdata = {{(OUT_DATA_W-BTN_W){1'b0}}, out_evt.button_number};
    assign m_axis_tuser = out_evt.pressed;
    assign m_axis_tlast = out_evt.last_event;

    // A tick with no flags changes nothing
    a_idle_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[7:0] == 8'h00)
        |=> (!stat.busy && stat.armed == $past(stat.armed)))
        else $error("zero-flag tick changed scanner state");

    // A flagged tick while armed starts a scan
    a_scan_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready && s_axis_tdata[7:0] != 8'h00 && stat.armed)
        |=> (stat.busy && !s_axis_tready))
        else $error("armed tick did not start a scan");

    // A scan only begins on an accepted item
    a_busy_cause: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(stat.busy) |-> $past(s_axis_tvalid && s_axis_tready))
        else $error("scan started without an input item");

    // An event is handed to the output stage only when it has room
    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && m_axis_tvalid) |-> m_axis_tready)
        else $error("event pushed into an occupied output slot");

endmodule

[dv/tb_key_matrix_change_scanner.sv]
// Self-checking testbench for key_matrix_change_scanner: directed and random poll ticks,
// scored against an in-bench prediction of the key events. Depends on kmcs_pkg and the RTL.
module tb_key_matrix_change_scanner
    import kmcs_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_CYCLES = 40;
    localparam int MAX_SHOWN    = 10;
    localparam logic [PADDR_W-1:0] EVENTS_EN_ADDR = PADDR_W'(4 * int'(REG_EVENTS_EN));

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata = '0;   // [7:0] change_flags, [71:8] scan_rows
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;         // [5:0] button_number, [7:6] zero
    logic                  m_axis_tuser;         // [0] pressed
    logic                  m_axis_tlast;
    logic                  psel = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite = 1'b0;
    logic [PADDR_W-1:0]    paddr = '0;
    logic [31:0]           pwdata = '0;
    logic [31:0]           prdata;
    logic                  pready;

    logic [IN_DATA_W-1:0] tick_queue [$];
    t_evt                 key_event_queue [$];

    logic [ROW_W-1:0] stored_rows [COLUMNS];
    logic             debounce_on;
    logic             events_on;
    int               idle_pct;
    int               stall_pct;
    int               mismatches;
    logic [63:0]      gen_rows;

    key_matrix_change_scanner uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // Expected key events of one accepted tick
    function automatic void predict_key_events(input logic [ROW_W-1:0] flags,
                                               input logic [63:0] rows);
        logic [2:0]       pos;
        logic [ROW_W-1:0] act;
        t_evt             ev;
        t_evt             tick_events [$];
        if (flags == '0) return;
        if (!debounce_on) begin
            debounce_on = 1'b1;
            return;
        end
        pos = {|(flags & MASK_HIGH), |(flags & MASK_PAIR), |(flags & MASK_ODD)};
        for (int k = 0; k < COLUMNS; k++) begin
            act = rows[8*k +: 8];
            if ((act & flags) != (stored_rows[k] & flags)) begin
                if (events_on) begin
                    ev.pressed       = |(act & flags);
                    ev.button_number = BTN_W'(k * 8 + int'(pos));
                    ev.last_event    = 1'b0;
                    tick_events.push_back(ev);
                end
                stored_rows[k] = act;
            end
        end
        if (tick_events.size() != 0) tick_events[tick_events.size() - 1].last_event = 1'b1;
        foreach (tick_events[i]) key_event_queue.push_back(tick_events[i]);
        debounce_on = 1'b0;
    endfunction

    // Tick driver
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || s_axis_tready) begin
            if (tick_queue.size() != 0 && $urandom_range(0, 99) >= idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= tick_queue.pop_front();
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Event sink back-pressure
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    // Monitor: score events first, then predict from the tick taken at this edge
    always @(posedge i_clk) begin
        t_evt want;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (key_event_queue.size() == 0) begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected event: tdata %h tuser %b tlast %b",
                                 m_axis_tdata, m_axis_tuser, m_axis_tlast);
                end else begin
                    want = key_event_queue.pop_front();
                    if (m_axis_tdata != OUT_DATA_W'(want.button_number) ||
                        m_axis_tuser != want.pressed || m_axis_tlast != want.last_event) begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display({"event mismatch: exp btn %0d pressed %b last %b, ",
                                      "got tdata %h tuser %b tlast %b"},
                                     want.button_number, want.pressed, want.last_event,
                                     m_axis_tdata, m_axis_tuser, m_axis_tlast);
                    end
                end
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_key_events(s_axis_tdata[ROW_W-1:0], s_axis_tdata[IN_DATA_W-1:ROW_W]);
        end
    end

    task automatic apb_write(input logic [PADDR_W-1:0] addr, input logic [31:0] data);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == EVENTS_EN_ADDR) events_on = data[0];
    endtask

    function automatic void push_tick(input logic [ROW_W-1:0] flags, input logic [63:0] rows);
        tick_queue.push_back({rows, flags});
    endfunction

    // Mostly arm/scan pairs, with some zero-flag noise
    function automatic void push_random_ticks(input int n);
        int               made;
        int               pick;
        logic [ROW_W-1:0] flags;
        logic [63:0]      rows;
        made = 0;
        while (made < n) begin
            pick = $urandom_range(0, 99);
            if (pick < 10)      flags = '0;
            else if (pick < 60) flags = ROW_W'(1 << $urandom_range(0, 7));
            else                flags = ROW_W'($urandom_range(1, 255));
            rows = {$urandom, $urandom};
            // reuse some previous bytes so unchanged columns show up
            if ($urandom_range(0, 2) == 0) begin
                for (int k = 0; k < 8; k++)
                    if ($urandom_range(0, 1) == 1) rows[8*k +: 8] = gen_rows[8*k +: 8];
            end
            gen_rows = rows;
            push_tick(flags, rows);
            made++;
        end
    endfunction

    // Settle: ticks all taken, events all seen, then let a scan with no events finish
    task automatic wait_quiet();
        while (tick_queue.size() != 0 || s_axis_tvalid) @(posedge i_clk);
        while (key_event_queue.size() != 0) @(posedge i_clk);
        repeat (QUIET_CYCLES) @(posedge i_clk);
    endtask

    task automatic run_phase(input int idle, input int stall, input logic en, input int n);
        idle_pct  = idle;
        stall_pct = stall;
        apb_write(EVENTS_EN_ADDR, {31'd0, en});
        push_random_ticks(n);
        wait_quiet();
    endtask

    initial begin
        for (int k = 0; k < COLUMNS; k++) stored_rows[k] = '0;
        debounce_on = 1'b0;
        events_on   = 1'b0;
        idle_pct    = 0;
        stall_pct   = 0;
        mismatches  = 0;
        gen_rows    = '0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        apb_write(EVENTS_EN_ADDR, 32'd1);
        // zero flags do nothing, here while not armed
        push_tick(8'h00, {$urandom, $urandom});
        push_tick(8'h00, '1);
        // every single row bit: arm, then scan
        for (int b = 0; b < 8; b++) begin
            push_tick(ROW_W'(1 << b), '0);
            push_tick(ROW_W'(1 << b), (b % 2 == 0) ? '1 : {$urandom, $urandom});
        end
        // all flags: position ORs to 7
        push_tick(8'hFF, '1);
        push_tick(8'hFF, '0);
        // two flags, ORed position
        push_tick(8'h03, '0);
        push_tick(8'h03, 64'h0102_0300_0102_0300);
        wait_quiet();

        run_phase(0, 0, 1'b1, 30);
        run_phase(88, 0, 1'b1, 30);
        run_phase(0, 88, 1'b1, 30);
        run_phase(14, 14, 1'b1, 30);
        run_phase(0, 0, 1'b0, 30);
        run_phase(14, 14, 1'b1, 28);

        if (mismatches == 0 && key_event_queue.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("status: fail");
        $finish;
    end

endmodule
